// ===== rtl/vbp_pkg.sv =====
// Shared types and constants of the voxel brush paint block.
// No dependencies; used by vbp_axis and voxel_brush_paint.
package vbp_pkg;

	// configuration register indexes and widths
	localparam int CFG_IDX_BITS = 4;
	localparam logic [CFG_IDX_BITS-1:0] REG_VOLUME_EXTENT = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_SIZE    = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_MODE    = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAINT_LABEL   = 4'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPLACE_LABEL = 4'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_X      = 4'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_Y      = 4'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_Z      = 4'd7;

	localparam int SIZE_BITS   = 9;
	localparam int MODE_BITS   = 2;
	localparam int LBL_REG_BITS = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int LIM_BITS    = SIZE_BITS + FRAC_BITS;
	localparam int LIMSQ_BITS  = 2 * LIM_BITS;

	localparam int MODE_ROUND   = 0;
	localparam int MODE_REPLACE = 1;

	localparam logic [SIZE_BITS-1:0]    SIZE_RESET   = 9'd1;
	localparam logic [MODE_BITS-1:0]    MODE_RESET   = 2'b01;
	localparam logic [LBL_REG_BITS-1:0] PAINT_RESET  = 16'd1;
	localparam logic [LBL_REG_BITS-1:0] REPL_RESET   = 16'd0;
	localparam logic [WEIGHT_BITS-1:0]  WEIGHT_UNITY = 16'd256;

	// per-stage load enables handed to the axis datapaths
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

endpackage

// ===== rtl/vbp_axis.sv =====
// One axis of the brush test: position range check, scaled magnitude, square.
// Depends on vbp_pkg (stage_en_t, WEIGHT_BITS).
module vbp_axis #(
	parameter int COORD_BITS = 12
) (
	input  logic                                       clk,
	input  vbp_pkg::stage_en_t                         en,
	input  logic [COORD_BITS-1:0]                      center,
	input  logic [COORD_BITS-1:0]                      offset,
	input  logic [COORD_BITS-1:0]                      last,
	input  logic [vbp_pkg::WEIGHT_BITS-1:0]            weight,
	output logic                                       inside_s3,
	output logic [COORD_BITS+vbp_pkg::WEIGHT_BITS-1:0] scaled_s2,
	output logic [2*(COORD_BITS+vbp_pkg::WEIGHT_BITS)-1:0] sq_s3
);

	localparam int S_W = COORD_BITS + vbp_pkg::WEIGHT_BITS;

	logic signed [COORD_BITS+1:0] pos;
	logic                         inside_c;
	logic [COORD_BITS-1:0]        mag_c;

	logic                  inside_s1, inside_s2;
	logic [COORD_BITS-1:0] mag_s1;

	always_comb begin
		pos = $signed({2'b00, center}) + $signed({{2{offset[COORD_BITS-1]}}, offset});
		inside_c = !pos[COORD_BITS+1] && (pos[COORD_BITS:0] <= {1'b0, last});
		// most negative offset maps onto its own unsigned magnitude
		mag_c = offset[COORD_BITS-1] ? (~offset + 1'b1) : offset;
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			inside_s1 <= inside_c;
			mag_s1    <= mag_c;
		end
		if (en.en_s2) begin
			inside_s2 <= inside_s1;
			scaled_s2 <= S_W'(mag_s1) * S_W'(weight);
		end
		if (en.en_s3) begin
			inside_s3 <= inside_s2;
			sq_s3     <= (2*S_W)'(scaled_s2) * (2*S_W)'(scaled_s2);
		end
	end

endmodule

// ===== rtl/voxel_brush_paint.sv =====
// Top level of the voxel brush paint block: config registers, stage control, final compare.
// Depends on vbp_pkg and vbp_axis.
//
// channel   | dir | handshake              | contents
// s_axis    | in  | s_axis_tvalid/tready   | one voxel: center, offset, current label
// m_axis    | out | m_axis_tvalid/tready   | new label, in-brush and changed flags
// cfg       | in  | cfg_valid/cfg_ready    | register index and write data
//
// Four register stages: range check and magnitude, weight multiply, square,
// sum and label select. One beat a cycle while the output is not stalled.
// Each stage holds its beat while the one after it is full and stalled; bubbles close up.
// arst_n clears the valid bits and loads the register reset values. cfg_ready is always high.
module voxel_brush_paint #(
	parameter int COORD_BITS = 12,
	parameter int LABEL_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// tdata from bit 0: center_x, center_y, center_z, offset_x, offset_y, offset_z,
	// current_label, zero fill
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [((6*COORD_BITS+LABEL_BITS+7)/8)*8-1:0] s_axis_tdata,
	// tdata from bit 0: new_label, zero fill
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((LABEL_BITS+7)/8)*8-1:0]         m_axis_tdata,
	// tuser from bit 0: in_brush, label_changed
	output logic [1:0]                              m_axis_tuser,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [vbp_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [((3*COORD_BITS > 16) ? 3*COORD_BITS : 16)-1:0] cfg_data
);

	localparam int EXT_W    = 3 * COORD_BITS;
	localparam int IN_W     = 6 * COORD_BITS + LABEL_BITS;
	localparam int OUT_TD_W = ((LABEL_BITS + 7) / 8) * 8;
	localparam int S_W      = COORD_BITS + vbp_pkg::WEIGHT_BITS;
	localparam int SQ_W     = 2 * S_W;
	localparam int SUM_W    = SQ_W + 2;

	// configuration registers
	logic [EXT_W-1:0]                  extent_q;
	logic [vbp_pkg::SIZE_BITS-1:0]     size_q;
	logic [vbp_pkg::MODE_BITS-1:0]     mode_q;
	logic [vbp_pkg::LBL_REG_BITS-1:0]  paint_q, replace_q;
	logic [vbp_pkg::WEIGHT_BITS-1:0]   weight_x_q, weight_y_q, weight_z_q;
	logic [vbp_pkg::LIMSQ_BITS-1:0]    limsq_q;
	logic [vbp_pkg::LIM_BITS-1:0]      lim;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_q   <= '1;
			size_q     <= vbp_pkg::SIZE_RESET;
			mode_q     <= vbp_pkg::MODE_RESET;
			paint_q    <= vbp_pkg::PAINT_RESET;
			replace_q  <= vbp_pkg::REPL_RESET;
			weight_x_q <= vbp_pkg::WEIGHT_UNITY;
			weight_y_q <= vbp_pkg::WEIGHT_UNITY;
			weight_z_q <= vbp_pkg::WEIGHT_UNITY;
		end else if (cfg_valid) begin
			case (cfg_index)
				vbp_pkg::REG_VOLUME_EXTENT: extent_q   <= cfg_data[EXT_W-1:0];
				vbp_pkg::REG_BRUSH_SIZE:    size_q     <= cfg_data[vbp_pkg::SIZE_BITS-1:0];
				vbp_pkg::REG_BRUSH_MODE:    mode_q     <= cfg_data[vbp_pkg::MODE_BITS-1:0];
				vbp_pkg::REG_PAINT_LABEL:   paint_q    <= cfg_data[vbp_pkg::LBL_REG_BITS-1:0];
				vbp_pkg::REG_REPLACE_LABEL: replace_q  <= cfg_data[vbp_pkg::LBL_REG_BITS-1:0];
				vbp_pkg::REG_WEIGHT_X:      weight_x_q <= cfg_data[vbp_pkg::WEIGHT_BITS-1:0];
				vbp_pkg::REG_WEIGHT_Y:      weight_y_q <= cfg_data[vbp_pkg::WEIGHT_BITS-1:0];
				vbp_pkg::REG_WEIGHT_Z:      weight_z_q <= cfg_data[vbp_pkg::WEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// radius in Q9.8; size zero wraps here but is masked at the compare
	assign lim = {size_q - 1'b1, {vbp_pkg::FRAC_BITS{1'b0}}};

	// squared limit is registered from lim and settles in the cycle after a size write, well before any beat needs it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limsq_q <= '0;
		else
			limsq_q <= vbp_pkg::LIMSQ_BITS'(lim) * vbp_pkg::LIMSQ_BITS'(lim);
	end

	// stage control
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	vbp_pkg::stage_en_t en;

	always_comb begin
		rdy4 = !vld_s4 || m_axis_tready;
		rdy3 = !vld_s3 || rdy4;
		rdy2 = !vld_s2 || rdy3;
		rdy1 = !vld_s1 || rdy2;
		en.en_s1 = rdy1;
		en.en_s2 = rdy2;
		en.en_s3 = rdy3;
	end

	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	// input unpack
	logic [COORD_BITS-1:0] cx, cy, cz, ox, oy, oz;
	logic [LABEL_BITS-1:0] cur_in;

	always_comb begin
		cx     = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
		cy     = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
		cz     = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
		ox     = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
		oy     = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
		oz     = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
		cur_in = s_axis_tdata[IN_W-1 -: LABEL_BITS];
	end

	logic             ins_x_s3, ins_y_s3, ins_z_s3;
	logic [S_W-1:0]   sx_s2, sy_s2, sz_s2;
	logic [SQ_W-1:0]  qx_s3, qy_s3, qz_s3;

	vbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk(clk), .en(en), .center(cx), .offset(ox),
		.last(extent_q[0*COORD_BITS +: COORD_BITS]), .weight(weight_x_q),
		.inside_s3(ins_x_s3), .scaled_s2(sx_s2), .sq_s3(qx_s3)
	);

	vbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk(clk), .en(en), .center(cy), .offset(oy),
		.last(extent_q[1*COORD_BITS +: COORD_BITS]), .weight(weight_y_q),
		.inside_s3(ins_y_s3), .scaled_s2(sy_s2), .sq_s3(qy_s3)
	);

	vbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
		.clk(clk), .en(en), .center(cz), .offset(oz),
		.last(extent_q[2*COORD_BITS +: COORD_BITS]), .weight(weight_z_q),
		.inside_s3(ins_z_s3), .scaled_s2(sz_s2), .sq_s3(qz_s3)
	);

	// label carried alongside; box test and label match done in stage 3
	logic [LABEL_BITS-1:0] cur_s1, cur_s2, cur_s3;
	logic                  box_s3, match_s3;
	logic [S_W-1:0]        lim_s;

	assign lim_s = S_W'(lim);

	always_ff @(posedge clk) begin
		if (rdy1) cur_s1 <= cur_in;
		if (rdy2) cur_s2 <= cur_s1;
		if (rdy3) begin
			cur_s3   <= cur_s2;
			// max below the limit is every component below it
			box_s3   <= (sx_s2 <= lim_s) && (sy_s2 <= lim_s) && (sz_s2 <= lim_s);
			match_s3 <= (cur_s2 == LABEL_BITS'(replace_q));
		end
	end

	// stage 4: sum of squares, coverage and label select
	logic [SUM_W-1:0]      sum;
	logic                  covered;
	logic [LABEL_BITS-1:0] next_label;

	always_comb begin
		sum = SUM_W'(qx_s3) + SUM_W'(qy_s3) + SUM_W'(qz_s3);
		covered = ins_x_s3 && ins_y_s3 && ins_z_s3 && (size_q != '0) &&
		          (mode_q[vbp_pkg::MODE_ROUND] ? (sum <= SUM_W'(limsq_q)) : box_s3);
		if (covered && (!mode_q[vbp_pkg::MODE_REPLACE] || match_s3))
			next_label = LABEL_BITS'(paint_q);
		else
			next_label = cur_s3;
	end

	logic [LABEL_BITS-1:0] label_s4;
	logic                  in_brush_s4, changed_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			label_s4    <= next_label;
			in_brush_s4 <= covered;
			changed_s4  <= (next_label != cur_s3);
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = OUT_TD_W'(label_s4);
	assign m_axis_tuser  = {changed_s4, in_brush_s4};

endmodule
